@@ rtl/rbe_pkg.sv @@
// Shared constants, types and state encodings for the byte RSA encryption block.
// Used by every module under rtl/; it depends on nothing else.
`default_nettype none

package rbe_pkg;

   // Arithmetic width of the modulus and of every residue.
   localparam int ModWidth     = 32;
   localparam int MulCntWidth  = $clog2(ModWidth);

   // Configuration port.
   localparam int CsrWidth      = 32;
   localparam int CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CSR_MODULUS  = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CSR_EXPONENT = CsrIndexWidth'(1);

   // Message byte and exponent.
   localparam int ByteWidth    = 8;
   localparam int ByteCntWidth = $clog2(ByteWidth);
   localparam int ExpWidth     = 32;
   localparam int ExpCntWidth  = $clog2(ExpWidth);
   localparam int WordWidth    = 32;

   // Reset values of the configuration registers.
   localparam logic [63:0]         ModulusReset  = 64'd3233;
   localparam logic [ExpWidth-1:0] ExponentReset = ExpWidth'(17);

   // Queue between front and back.
   localparam int QueueDepth = 2;
   localparam int QPtrWidth  = $clog2(QueueDepth);
   localparam int QCntWidth  = $clog2(QueueDepth + 1);

   typedef logic [ModWidth-1:0] residue_type;

   // One classified item: reduced message and a flag for a zero modulus.
   typedef struct packed {
      residue_type msg;
      logic        zero_mod;
   } q_entry_type;

   // Status of the modular multiplier as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_REDUCE,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SQUARE,
      BK_SQ_WAIT,
      BK_MULT,
      BK_MUL_WAIT,
      BK_OUTPUT
   } back_state_type;

endpackage

`default_nettype wire

@@ rtl/rbe_front.sv @@
// Front end: accepts a message byte, reduces it modulo N one bit per cycle
// and pushes the classified item into the queue. Depends on rbe_pkg.
`default_nettype none

module rbe_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [rbe_pkg::ByteWidth-1:0] req_message_byte,
   input  wire rbe_pkg::residue_type    modulus,
   input  wire logic                    q_full,
   output logic                         q_push,
   output rbe_pkg::q_entry_type         q_wdata
);

   rbe_pkg::front_state_type                state_ff, state_in;
   logic [rbe_pkg::ByteWidth-1:0]           byte_ff, byte_in;
   logic [rbe_pkg::ByteCntWidth-1:0]        cnt_ff, cnt_in;
   rbe_pkg::residue_type                    rem_ff, rem_in;
   logic [rbe_pkg::ModWidth:0]              trial;
   logic [rbe_pkg::ModWidth:0]              diff;
   logic                                    accept;
   logic                                    last_bit;

   assign accept   = req_valid && req_ready;
   assign last_bit = (cnt_ff == rbe_pkg::ByteCntWidth'(rbe_pkg::ByteWidth - 1));

   // Restoring reduction step: shift in the next message bit, subtract N if it fits.
   assign trial = {rem_ff, byte_ff[rbe_pkg::ByteWidth-1]};
   assign diff  = trial - {1'b0, modulus};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbe_pkg::FR_IDLE: begin
            if (req_valid) state_in = rbe_pkg::FR_REDUCE;
         end
         rbe_pkg::FR_REDUCE: begin
            if (last_bit) state_in = rbe_pkg::FR_PUSH;
         end
         rbe_pkg::FR_PUSH: begin
            if (!q_full) state_in = rbe_pkg::FR_IDLE;
         end
         default: state_in = rbe_pkg::FR_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_ready = 1'b0;
      q_push    = 1'b0;
      unique case (state_ff)
         rbe_pkg::FR_IDLE:   req_ready = 1'b1;
         rbe_pkg::FR_REDUCE: ;
         rbe_pkg::FR_PUSH:   q_push    = !q_full;
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      byte_in = byte_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      if (accept) begin
         byte_in = req_message_byte;
         cnt_in  = '0;
         rem_in  = '0;
      end else if (state_ff == rbe_pkg::FR_REDUCE) begin
         byte_in = {byte_ff[rbe_pkg::ByteWidth-2:0], 1'b0};
         cnt_in  = cnt_ff + rbe_pkg::ByteCntWidth'(1);
         if (trial >= {1'b0, modulus}) begin
            rem_in = diff[rbe_pkg::ModWidth-1:0];
         end else begin
            rem_in = trial[rbe_pkg::ModWidth-1:0];
         end
      end
   end

   assign q_wdata.msg      = rem_ff;
   assign q_wdata.zero_mod = (modulus == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbe_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      byte_ff <= byte_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
   end

endmodule

`default_nettype wire

@@ rtl/rbe_queue.sv @@
// Two-entry queue of classified items between the front end and the sequencer.
// Depends on rbe_pkg.
`default_nettype none

module rbe_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rbe_pkg::q_entry_type wdata,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      valid,
   output rbe_pkg::q_entry_type      rdata
);

   rbe_pkg::q_entry_type             mem_ff [rbe_pkg::QueueDepth];
   logic [rbe_pkg::QPtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rbe_pkg::QPtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rbe_pkg::QCntWidth-1:0]    count_ff, count_in;

   localparam logic [rbe_pkg::QPtrWidth-1:0] LastPtr =
      rbe_pkg::QPtrWidth'(rbe_pkg::QueueDepth - 1);

   assign full  = (count_ff == rbe_pkg::QCntWidth'(rbe_pkg::QueueDepth));
   assign valid = (count_ff != '0);
   assign rdata = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + rbe_pkg::QPtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + rbe_pkg::QPtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + rbe_pkg::QCntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rbe_pkg::QCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   // The front end never pushes into a full queue, the sequencer never pops an empty one.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> valid)
      else $error("queue pop while empty");

endmodule

`default_nettype wire

@@ rtl/rbe_modmul.sv @@
// Shift-add modular multiplier: one bit of the multiplier per cycle, most
// significant first, accumulator kept below N. Depends on rbe_pkg.
`default_nettype none

module rbe_modmul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire rbe_pkg::residue_type a,
   input  wire rbe_pkg::residue_type b,
   input  wire rbe_pkg::residue_type modulus,
   output rbe_pkg::mul_status_type   status,
   output rbe_pkg::residue_type      product
);

   localparam int StepWidth = rbe_pkg::ModWidth + 2;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [rbe_pkg::MulCntWidth-1:0]   cnt_ff, cnt_in;
   rbe_pkg::residue_type              acc_ff, acc_in;
   rbe_pkg::residue_type              a_ff, a_in;
   rbe_pkg::residue_type              b_ff, b_in;
   logic [StepWidth-1:0]              sum;
   logic [StepWidth-1:0]              sub_one;
   logic [StepWidth-1:0]              sub_two;
   logic [StepWidth-1:0]              n_one;
   logic [StepWidth-1:0]              n_two;
   rbe_pkg::residue_type              step_result;
   logic                              last_step;

   // One step: 2*acc plus a when the bit is set; the sum stays below 3N,
   // so subtracting N or 2N brings it back into range.
   assign n_one   = {2'b00, modulus};
   assign n_two   = {1'b0, modulus, 1'b0};
   assign sum     = {1'b0, acc_ff, 1'b0}
                    + (b_ff[rbe_pkg::ModWidth-1] ? {2'b00, a_ff} : StepWidth'(0));
   assign sub_one = sum - n_one;
   assign sub_two = sum - n_two;

   always_comb begin
      priority if (sum >= n_two) begin
         step_result = sub_two[rbe_pkg::ModWidth-1:0];
      end else if (sum >= n_one) begin
         step_result = sub_one[rbe_pkg::ModWidth-1:0];
      end else begin
         step_result = sum[rbe_pkg::ModWidth-1:0];
      end
   end

   assign last_step = (cnt_ff == rbe_pkg::MulCntWidth'(rbe_pkg::ModWidth - 1));

   // Control and operand registers.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
      end else if (busy_ff) begin
         acc_in = step_result;
         b_in   = {b_ff[rbe_pkg::ModWidth-2:0], 1'b0};
         cnt_in = cnt_ff + rbe_pkg::MulCntWidth'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

endmodule

`default_nettype wire

@@ rtl/rbe_back.sv @@
// Back end: left-to-right square-and-multiply sequencer around the modular
// multiplier, with the result output register. Depends on rbe_pkg, rbe_modmul.
`default_nettype none

module rbe_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire rbe_pkg::q_entry_type          q_rdata,
   output logic                               q_pop,
   input  wire rbe_pkg::residue_type          modulus,
   input  wire logic [rbe_pkg::ExpWidth-1:0]  exponent,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [rbe_pkg::WordWidth-1:0]      rsp_cipher_word
);

   rbe_pkg::back_state_type               state_ff, state_in;
   rbe_pkg::residue_type                  msg_ff, msg_in;
   rbe_pkg::residue_type                  r_ff, r_in;
   logic [rbe_pkg::ExpWidth-1:0]          e_ff, e_in;
   logic [rbe_pkg::ExpCntWidth-1:0]       bit_cnt_ff, bit_cnt_in;
   logic                                  zero_ff, zero_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [rbe_pkg::WordWidth-1:0]         rsp_word_ff, rsp_word_in;

   rbe_pkg::mul_status_type               mul_stat;
   rbe_pkg::residue_type                  mul_product;
   rbe_pkg::residue_type                  mul_a;
   logic                                  mul_start;
   logic                                  load_item;
   logic                                  load_product;
   logic                                  advance_bit;
   logic                                  load_result;
   logic                                  out_free;
   logic                                  last_bit;
   logic                                  e_bit;
   logic [63:0]                           r_wide;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_bit = (bit_cnt_ff == rbe_pkg::ExpCntWidth'(rbe_pkg::ExpWidth - 1));
   assign e_bit    = e_ff[rbe_pkg::ExpWidth-1];
   assign mul_a    = (state_ff == rbe_pkg::BK_MULT) ? msg_ff : r_ff;

   rbe_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (r_ff),
      .modulus (modulus),
      .status  (mul_stat),
      .product (mul_product)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbe_pkg::BK_IDLE: begin
            if (q_valid) begin
               state_in = q_rdata.zero_mod ? rbe_pkg::BK_OUTPUT : rbe_pkg::BK_SQUARE;
            end
         end
         rbe_pkg::BK_SQUARE: state_in = rbe_pkg::BK_SQ_WAIT;
         rbe_pkg::BK_SQ_WAIT: begin
            if (mul_stat.done) begin
               priority if (e_bit) state_in = rbe_pkg::BK_MULT;
               else if (last_bit)  state_in = rbe_pkg::BK_OUTPUT;
               else                state_in = rbe_pkg::BK_SQUARE;
            end
         end
         rbe_pkg::BK_MULT: state_in = rbe_pkg::BK_MUL_WAIT;
         rbe_pkg::BK_MUL_WAIT: begin
            if (mul_stat.done) begin
               state_in = last_bit ? rbe_pkg::BK_OUTPUT : rbe_pkg::BK_SQUARE;
            end
         end
         rbe_pkg::BK_OUTPUT: begin
            if (out_free) state_in = rbe_pkg::BK_IDLE;
         end
         default: state_in = rbe_pkg::BK_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      q_pop        = 1'b0;
      load_item    = 1'b0;
      mul_start    = 1'b0;
      load_product = 1'b0;
      advance_bit  = 1'b0;
      load_result  = 1'b0;
      unique case (state_ff)
         rbe_pkg::BK_IDLE: begin
            q_pop     = q_valid;
            load_item = q_valid;
         end
         rbe_pkg::BK_SQUARE: mul_start = 1'b1;
         rbe_pkg::BK_SQ_WAIT: begin
            load_product = mul_stat.done;
            advance_bit  = mul_stat.done && !e_bit;
         end
         rbe_pkg::BK_MULT: mul_start = 1'b1;
         rbe_pkg::BK_MUL_WAIT: begin
            load_product = mul_stat.done;
            advance_bit  = mul_stat.done;
         end
         rbe_pkg::BK_OUTPUT: load_result = out_free;
         default: ;
      endcase
   end

   assign r_wide = 64'(r_ff);

   // Datapath next values.
   always_comb begin
      msg_in       = msg_ff;
      r_in         = r_ff;
      e_in         = e_ff;
      bit_cnt_in   = bit_cnt_ff;
      zero_in      = zero_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_item) begin
         msg_in     = q_rdata.msg;
         // The running power starts at 1 mod N, which is 0 for a unit modulus.
         r_in       = rbe_pkg::residue_type'(modulus != rbe_pkg::residue_type'(1));
         e_in       = exponent;
         bit_cnt_in = '0;
         zero_in    = q_rdata.zero_mod;
      end
      if (load_product) begin
         r_in = mul_product;
      end
      if (advance_bit) begin
         e_in       = {e_ff[rbe_pkg::ExpWidth-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + rbe_pkg::ExpCntWidth'(1);
      end
      if (load_result) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = zero_ff ? '0 : r_wide[rbe_pkg::WordWidth-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_word = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbe_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      msg_ff      <= msg_in;
      r_ff        <= r_in;
      e_ff        <= e_in;
      bit_cnt_ff  <= bit_cnt_in;
      zero_ff     <= zero_in;
      rsp_word_ff <= rsp_word_in;
   end

   // The multiplier is only started when it is free.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   // While waiting on a product the multiplier is either running or just finished.
   a_wait_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbe_pkg::BK_SQ_WAIT || state_ff == rbe_pkg::BK_MUL_WAIT)
      |-> (mul_stat.busy || mul_stat.done))
      else $error("sequencer waiting on an idle multiplier");

   // A new result only appears out of the output state.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rbe_pkg::BK_OUTPUT))
      else $error("result raised outside the output state");

endmodule

`default_nettype wire

@@ rtl/rsa_byte_encrypt_modexp.sv @@
// Top level of the byte RSA encryption block: configuration registers, front end,
// item queue and exponentiation back end. Depends on rbe_pkg and the rtl/ rbe_ modules.
//
// Usage:
//   Each beat on the req_ channel carries one plaintext byte. The block returns
//   one beat on the rsp_ channel with cipher_word = byte^E mod N, in order.
//   N and E are written through the csr_ port (index 0: modulus, index 1:
//   public exponent); writes take effect at once. The user must write them
//   only while no item is in flight; the block itself does not enforce this.
//   The front end reduces a byte modulo N and holds it in a two-entry queue,
//   so it takes the next byte while the back end works.
//   The back end runs one square per exponent bit and one extra multiply per
//   set bit on the shift-add multiplier, which sets the throughput.
//   A zero modulus gives 0 without running the multiplier.
//   Reset clears all control state and loads N = 3233, E = 17.
//   When the receiver stalls, the result waits in the output register; the
//   back end finishes its next item and holds it, and the queue and front end
//   fill, after which req_ready stays low.
`default_nettype none

module rsa_byte_encrypt_modexp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [rbe_pkg::ByteWidth-1:0]       req_message_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [rbe_pkg::WordWidth-1:0]            rsp_cipher_word,
   input  wire logic                                csr_write_en,
   input  wire logic [rbe_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [rbe_pkg::CsrWidth-1:0]        csr_wdata
);

   rbe_pkg::residue_type                 modulus_ff, modulus_in;
   logic [rbe_pkg::ExpWidth-1:0]         exponent_ff, exponent_in;
   logic [63:0]                          csr_wide;

   logic                                 q_full;
   logic                                 q_push;
   logic                                 q_pop;
   logic                                 q_valid;
   rbe_pkg::q_entry_type                 q_wdata;
   rbe_pkg::q_entry_type                 q_rdata;

   // Configuration registers; the modulus keeps its low ModWidth bits.
   assign csr_wide = 64'(csr_wdata);

   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            rbe_pkg::CSR_MODULUS:  modulus_in  = csr_wide[rbe_pkg::ModWidth-1:0];
            rbe_pkg::CSR_EXPONENT: exponent_in = csr_wide[rbe_pkg::ExpWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= rbe_pkg::ModulusReset[rbe_pkg::ModWidth-1:0];
         exponent_ff <= rbe_pkg::ExponentReset;
      end else begin
         modulus_ff  <= modulus_in;
         exponent_ff <= exponent_in;
      end
   end

   rbe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_byte (req_message_byte),
      .modulus          (modulus_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   rbe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .rdata (q_rdata)
   );

   rbe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_rdata         (q_rdata),
      .q_pop           (q_pop),
      .modulus         (modulus_ff),
      .exponent        (exponent_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cipher_word (rsp_cipher_word)
   );

endmodule

`default_nettype wire

@@ dv/rbe_cipher_checker.sv @@
// Scoreboard for the byte RSA encryption block: it watches the req_, rsp_ and csr_ ports,
// predicts each cipher word from its own copy of N and E, and compares results in order.
// Depends on rbe_pkg for widths, register indexes and reset values.
module rbe_cipher_checker
   import rbe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [ByteWidth-1:0]     req_message_byte,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [WordWidth-1:0]     rsp_cipher_word,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]      csr_wdata,
   output int                       fail_count,
   output int                       pending_count
);

   localparam int ReportLimit = 10;

   // One cipher word still owed by the block, with what it was computed from.
   typedef struct {
      logic [ByteWidth-1:0] message;
      logic [ModWidth-1:0]  modulus;
      logic [ExpWidth-1:0]  exponent;
      logic [WordWidth-1:0] cipher;
   } cipher_expect_type;

   cipher_expect_type    owed_ciphers[$];
   cipher_expect_type    head;
   logic [ModWidth-1:0]  modulus_copy = ModWidth'(ModulusReset);
   logic [ExpWidth-1:0]  exponent_copy = ExponentReset;
   int                   failures = 0;

   // Exact m^E mod N by left-to-right square-and-multiply on 64-bit products.
   // Every residue stays below 2^32, so no product can overflow.
   function automatic logic [WordWidth-1:0] rsa_encrypt(input logic [ByteWidth-1:0] message,
                                                        input logic [ModWidth-1:0] modulus,
                                                        input logic [ExpWidth-1:0] exponent);
      logic [63:0] n;
      logic [63:0] base;
      logic [63:0] acc;
      n = 64'(modulus);
      if (n == 64'd0) begin
         return '0;
      end
      base = 64'(message) % n;
      acc  = 64'd1 % n;
      for (int i = ExpWidth - 1; i >= 0; i--) begin
         acc = (acc * acc) % n;
         if (exponent[i]) begin
            acc = (acc * base) % n;
         end
      end
      return WordWidth'(acc);
   endfunction

   task automatic report_failure(input string what);
      failures++;
      if (failures <= ReportLimit) begin
         $display("ERROR: %s", what);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         modulus_copy  = ModWidth'(ModulusReset);
         exponent_copy = ExponentReset;
         owed_ciphers.delete();
      end else begin
         // Retire the oldest expectation against each result beat.
         if (rsp_valid && rsp_ready) begin
            if (owed_ciphers.size() == 0) begin
               report_failure($sformatf("result beat with no input waiting, cipher_word=%0h",
                                        rsp_cipher_word));
            end else begin
               head = owed_ciphers.pop_front();
               if (rsp_cipher_word !== head.cipher) begin
                  report_failure($sformatf(
                     "cipher_word m=%0h N=%0h E=%0h: expected %0h, got %0h",
                     head.message, head.modulus, head.exponent, head.cipher,
                     rsp_cipher_word));
               end
            end
         end

         // Predict each accepted input beat with the key in force before this edge.
         if (req_valid && req_ready) begin
            head.message  = req_message_byte;
            head.modulus  = modulus_copy;
            head.exponent = exponent_copy;
            head.cipher   = rsa_encrypt(req_message_byte, modulus_copy, exponent_copy);
            owed_ciphers.push_back(head);
         end

         // Track register writes.
         if (csr_write_en) begin
            case (csr_index)
               CSR_MODULUS: begin
                  modulus_copy = ModWidth'(csr_wdata);
               end
               CSR_EXPONENT: begin
                  exponent_copy = ExpWidth'(csr_wdata);
               end
               default: begin
               end
            endcase
         end
      end
      fail_count    <= failures;
      pending_count <= owed_ciphers.size();
   end

endmodule

@@ dv/tb_top.sv @@
// Top of the byte RSA encryption testbench: clock, reset, key writes, byte stimulus and
// result back-pressure around the block, with rbe_cipher_checker doing all comparison.
// Depends on rbe_pkg, rsa_byte_encrypt_modexp and rbe_cipher_checker.
module tb_top;
   import rbe_pkg::*;

   localparam int CycleLimit   = 3_000_000;
   localparam int SettleCycles = 12;
   localparam int DrainCycles  = 60;
   localparam int RandomPhases = 9;
   localparam int PhaseItems   = 30;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [ByteWidth-1:0]     req_message_byte = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [WordWidth-1:0]     rsp_cipher_word;
   logic                     csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_MODULUS;
   logic [CsrWidth-1:0]      csr_wdata = '0;
   int                       fail_count;
   int                       pending_count;
   int                       cycle_count = 0;
   logic                     sender_calm = 1'b0;
   logic                     receiver_calm = 1'b1;
   logic [ModWidth-1:0]      key_modulus = ModWidth'(ModulusReset);

   rsa_byte_encrypt_modexp DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_byte (req_message_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cipher_word  (rsp_cipher_word),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   rbe_cipher_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_byte (req_message_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cipher_word  (rsp_cipher_word),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("rsa_byte_encrypt_modexp test failed");
         $finish;
      end
   end

   // Offer one message byte after a random gap and hold it until the beat is taken.
   task automatic send_byte(input logic [ByteWidth-1:0] message);
      int gap;
      if ($urandom_range(0, 15) == 0) begin
         sender_calm = !sender_calm;
      end
      gap = sender_calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_message_byte <= message;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Stop sending and wait until every owed cipher word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrWidth-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_key(input logic [CsrWidth-1:0] modulus,
                           input logic [CsrWidth-1:0] exponent);
      write_csr(CSR_MODULUS, modulus);
      write_csr(CSR_EXPONENT, exponent);
      key_modulus = ModWidth'(modulus);
   endtask

   // Random moduli span tiny (bytes often not below N), 16-bit, full 32-bit and degenerate.
   function automatic logic [CsrWidth-1:0] pick_modulus();
      case ($urandom_range(0, 5))
         0: return CsrWidth'($urandom_range(2, 255));
         1: return CsrWidth'($urandom_range(256, 65535));
         2: return CsrWidth'($urandom);
         3: return CsrWidth'($urandom) | 32'h8000_0000;
         4: return CsrWidth'($urandom) | 32'h0000_0001;
         default: return CsrWidth'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [CsrWidth-1:0] pick_exponent();
      case ($urandom_range(0, 4))
         0: return CsrWidth'($urandom_range(0, 3));
         1: return CsrWidth'($urandom_range(1, 65537));
         2: return 32'hFFFF_FFFF;
         default: return CsrWidth'($urandom);
      endcase
   endfunction

   function automatic logic [ByteWidth-1:0] pick_message();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return ByteWidth'(1);
         3: return (key_modulus != 0 && key_modulus <= 256) ?
                   ByteWidth'(key_modulus - 1) : ByteWidth'($urandom);
         default: return ByteWidth'($urandom);
      endcase
   endfunction

   // Result side: stall for a random number of cycles before taking each beat.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            receiver_calm = !receiver_calm;
         end
         stall = receiver_calm ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset key N = 3233, E = 17 with the byte extremes and alternating bit patterns.
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'hAA);
      drain_results();

      // Zero modulus has no residues, so every cipher word is zero.
      load_key(32'd0, 32'd17);
      send_byte(8'h00);
      send_byte(8'hFF);
      drain_results();

      // Unit modulus collapses everything to zero.
      load_key(32'd1, 32'd5);
      send_byte(8'h00);
      send_byte(8'h07);
      drain_results();

      // Zero exponent gives one, even for a zero message.
      load_key(32'd3233, 32'd0);
      send_byte(8'h00);
      send_byte(8'h09);
      drain_results();

      // Smallest real modulus: most bytes must be reduced first.
      load_key(32'd2, 32'd3);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'hFF);
      drain_results();

      // Largest modulus and exponent: the slowest item the block can see.
      load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_byte(8'hFF);
      send_byte(8'h02);
      drain_results();

      // Bytes just below, at and above the modulus with unit exponent.
      load_key(32'd200, 32'd1);
      send_byte(8'd199);
      send_byte(8'd200);
      send_byte(8'd255);
      drain_results();

      // Random keys, each followed by a stream of random bytes.
      for (int phase = 0; phase < RandomPhases; phase++) begin
         load_key(pick_modulus(), pick_exponent());
         for (int item = 0; item < PhaseItems; item++) begin
            send_byte(pick_message());
         end
         drain_results();
      end

      req_valid <= 1'b0;
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("rsa_byte_encrypt_modexp test passed");
      end else begin
         $display("rsa_byte_encrypt_modexp test failed");
      end
      $finish;
   end

endmodule

@@ rsa_byte_encrypt_modexp.f @@
rtl/rbe_pkg.sv
rtl/rbe_front.sv
rtl/rbe_queue.sv
rtl/rbe_modmul.sv
rtl/rbe_back.sv
rtl/rsa_byte_encrypt_modexp.sv
dv/rbe_cipher_checker.sv
dv/tb_top.sv
